### rtl/rmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, types and helpers for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int DATA_WIDTH = 16;

    // Sum of three entries, t, and one sum or difference of two entries.
    localparam int SUM_W = DATA_WIDTH + 2;
    localparam int T_W   = DATA_WIDTH + 3;
    localparam int D_W   = DATA_WIDTH + 1;

    // Radicand t << FRAC_BITS and its integer square root.
    localparam int RAD_W     = 2 * DATA_WIDTH;
    localparam int SQ_STAGES = RAD_W / 2;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int DEN_W     = ROOT_W + 1;

    // Dividend (|d| << FRAC_BITS) + r, one quotient bit per stage.
    localparam int NUM_W = D_W + FRAC_BITS;

    localparam int LATENCY = SQ_STAGES + NUM_W + 3;

    localparam int SAT_MAX     = 2 ** (DATA_WIDTH - 1) - 1;
    localparam int SAT_MIN_MAG = 2 ** (DATA_WIDTH - 1);

    typedef enum logic [1:0] {
        DOM_X = 2'd0,
        DOM_Y = 2'd1,
        DOM_Z = 2'd2,
        DOM_W = 2'd3
    } t_dom;

    typedef struct packed {
        logic                   valid;
        t_dom                   dom;
        logic                   invalid;
        logic [RAD_W-1:0]       rad;
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
        logic signed [D_W-1:0]  dz;
        logic signed [D_W-1:0]  dw;
    } t_front;

    typedef struct packed {
        logic                  valid;
        t_dom                  dom;
        logic                  invalid;
        logic [DATA_WIDTH-1:0] big;
    } t_meta;

    // Clamp a quotient magnitude and apply its sign.
    function automatic logic [DATA_WIDTH-1:0] rmq_sat(input logic [NUM_W-1:0] q,
                                                      input logic neg);
        logic [NUM_W-1:0] lim;
        logic [NUM_W-1:0] m;
        lim = neg ? NUM_W'(SAT_MIN_MAG) : NUM_W'(SAT_MAX);
        m   = (q > lim) ? lim : q;
        if (neg) begin
            m = ~m + 1'b1;
        end
        return m[DATA_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/rotation_matrix_to_quaternion_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Converts a 3x3 rotation matrix in signed Q2.14 into a quaternion using
// the trace form or the column form of the largest diagonal entry.
// ----------------------------------------------------------------------------
// Pipeline: 1 form-select stage, 16 square-root stages, 1 dividend stage, 31
// divider stages and 1 saturation stage. Throughput: one item per cycle, set
// by the fully pipelined square root and dividers; busy is therefore always
// low. Reset is synchronous and active low; it clears the valid bits of every
// stage, so items in flight are dropped. The receiver cannot stall.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [DATA_WIDTH-1:0] i_m11,
    input  wire logic signed [DATA_WIDTH-1:0] i_m12,
    input  wire logic signed [DATA_WIDTH-1:0] i_m13,
    input  wire logic signed [DATA_WIDTH-1:0] i_m21,
    input  wire logic signed [DATA_WIDTH-1:0] i_m22,
    input  wire logic signed [DATA_WIDTH-1:0] i_m23,
    input  wire logic signed [DATA_WIDTH-1:0] i_m31,
    input  wire logic signed [DATA_WIDTH-1:0] i_m32,
    input  wire logic signed [DATA_WIDTH-1:0] i_m33,
    output logic                              o_valid,
    output logic signed [DATA_WIDTH-1:0]      o_quat_x,
    output logic signed [DATA_WIDTH-1:0]      o_quat_y,
    output logic signed [DATA_WIDTH-1:0]      o_quat_z,
    output logic signed [DATA_WIDTH-1:0]      o_quat_w,
    output logic                              o_invalid
);

    // The pipeline never stalls, so an item is taken on every start.
    assign busy = 1'b0;

    t_front front_q;
    t_front sq_front;
    t_front sq_front_in_w;
    logic [ROOT_W-1:0] sq_root;

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_m11   (i_m11), .i_m12 (i_m12), .i_m13 (i_m13),
        .i_m21   (i_m21), .i_m22 (i_m22), .i_m23 (i_m23),
        .i_m31   (i_m31), .i_m32 (i_m32), .i_m33 (i_m33),
        .o_front (front_q)
    );

    assign sq_front_in_w = front_q;

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_front (sq_front_in_w),
        .o_front (sq_front),
        .o_root  (sq_root)
    );

    // Dividend stage: for each lane, |d| << FRAC_BITS plus r gives the
    // round-to-nearest dividend against the divisor 2r.
    logic [NUM_W-1:0] r_num [4];
    logic             r_neg [4];
    logic [DEN_W-1:0] r_den;
    t_meta            r_meta;
    logic [NUM_W-1:0] n_num [4];
    logic             n_neg [4];
    t_meta            n_meta;

    always_comb begin
        logic signed [D_W-1:0] dv [4];
        logic [D_W-1:0]        mag;
        dv[0] = sq_front.dx;
        dv[1] = sq_front.dy;
        dv[2] = sq_front.dz;
        dv[3] = sq_front.dw;
        for (int l = 0; l < 4; l++) begin
            n_neg[l] = dv[l][D_W-1];
            mag      = n_neg[l] ? D_W'(-dv[l]) : D_W'(dv[l]);
            n_num[l] = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(sq_root);
        end
        n_meta.valid   = sq_front.valid;
        n_meta.dom     = sq_front.dom;
        n_meta.invalid = sq_front.invalid;
        // The dominant component is r/2 rounded half up; it stays in range.
        n_meta.big     = DATA_WIDTH'((ROOT_W + 1)'(sq_root) + 1'b1 >> 1);
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            r_num[l] <= n_num[l];
            r_neg[l] <= n_neg[l];
        end
        r_den  <= {sq_root, 1'b0};
        r_meta <= n_meta;
        if (!i_rst_n) begin
            r_meta.valid <= 1'b0;
        end
    end

    // One divider per component; the dominant lane's quotient is unused.
    logic [NUM_W-1:0] quot [4];
    logic             qneg [4];

    for (genvar g = 0; g < 4; g++) begin : g_div
        rmq_div u_div (
            .i_clk  (i_clk),
            .i_num  (r_num[g]),
            .i_den  (r_den),
            .i_neg  (r_neg[g]),
            .o_quot (quot[g]),
            .o_neg  (qneg[g])
        );
    end

    // Item tag delay line that keeps pace with the divider stages.
    t_meta r_mdly [NUM_W];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_W; k++) begin
            r_mdly[k] <= (k == 0) ? r_meta : r_mdly[(k == 0) ? 0 : k - 1];
            if (!i_rst_n) begin
                r_mdly[k].valid <= 1'b0;
            end
        end
    end

    // Output stage: pick zero for an invalid item, else the dominant value or the saturated quotient.
    t_meta                 m_out;
    logic [DATA_WIDTH-1:0] n_q [4];
    logic                  r_valid;
    logic                  r_invalid;
    logic [DATA_WIDTH-1:0] r_q [4];

    assign m_out = r_mdly[NUM_W-1];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (m_out.invalid) begin
                n_q[l] = '0;
            end else if (m_out.dom == t_dom'(l)) begin
                n_q[l] = m_out.big;
            end else begin
                n_q[l] = rmq_sat(quot[l], qneg[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= m_out.valid;
        end
        r_invalid <= m_out.invalid;
        for (int l = 0; l < 4; l++) begin
            r_q[l] <= n_q[l];
        end
    end

    assign o_valid   = r_valid;
    assign o_invalid = r_invalid;
    assign o_quat_x  = r_q[0];
    assign o_quat_y  = r_q[1];
    assign o_quat_z  = r_q[2];
    assign o_quat_w  = r_q[3];

    // Every accepted item later appears at the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid)
        else $error("item did not emerge after the pipeline latency");

    // An invalid result carries an all-zero quaternion.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |->
            (o_quat_x == '0 && o_quat_y == '0 && o_quat_z == '0 && o_quat_w == '0))
        else $error("invalid result with nonzero quaternion");

    // No result appears without a matching accepted item.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_rst_n, LATENCY)) |-> $past(start, LATENCY))
        else $error("result without a matching item");

endmodule
`default_nettype wire

### rtl/rmq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_front
// Picks the form, forms t, the radicand and the three sums or differences.
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic signed [DATA_WIDTH-1:0] i_m11,
    input  wire logic signed [DATA_WIDTH-1:0] i_m12,
    input  wire logic signed [DATA_WIDTH-1:0] i_m13,
    input  wire logic signed [DATA_WIDTH-1:0] i_m21,
    input  wire logic signed [DATA_WIDTH-1:0] i_m22,
    input  wire logic signed [DATA_WIDTH-1:0] i_m23,
    input  wire logic signed [DATA_WIDTH-1:0] i_m31,
    input  wire logic signed [DATA_WIDTH-1:0] i_m32,
    input  wire logic signed [DATA_WIDTH-1:0] i_m33,
    output t_front                            o_front
);

    t_front r_out;
    t_front n_out;

    logic signed [SUM_W-1:0] trace;
    logic signed [T_W-1:0]   t_val;
    logic signed [T_W-1:0]   one;
    logic signed [D_W-1:0]   e12, e13, e21, e23, e31, e32;

    always_comb begin
        e12 = D_W'(i_m12); e13 = D_W'(i_m13);
        e21 = D_W'(i_m21); e23 = D_W'(i_m23);
        e31 = D_W'(i_m31); e32 = D_W'(i_m32);
        one   = T_W'(2 ** FRAC_BITS);
        trace = SUM_W'(i_m11) + SUM_W'(i_m22) + SUM_W'(i_m33);
        n_out = '0;
        n_out.valid = i_valid;
        priority if (trace > 0) begin
            n_out.dom = DOM_W;
            t_val     = one + T_W'(trace);
            n_out.dx  = e23 - e32;
            n_out.dy  = e31 - e13;
            n_out.dz  = e12 - e21;
        end else if (i_m11 > i_m22 && i_m11 > i_m33) begin
            n_out.dom = DOM_X;
            t_val     = one + T_W'(i_m11) - T_W'(i_m22) - T_W'(i_m33);
            n_out.dy  = e12 + e21;
            n_out.dz  = e13 + e31;
            n_out.dw  = e23 - e32;
        end else if (i_m22 > i_m33) begin
            n_out.dom = DOM_Y;
            t_val     = one + T_W'(i_m22) - T_W'(i_m11) - T_W'(i_m33);
            n_out.dx  = e21 + e12;
            n_out.dz  = e32 + e23;
            n_out.dw  = e31 - e13;
        end else begin
            n_out.dom = DOM_Z;
            t_val     = one + T_W'(i_m33) - T_W'(i_m11) - T_W'(i_m22);
            n_out.dx  = e31 + e13;
            n_out.dy  = e32 + e23;
            n_out.dw  = e12 - e21;
        end
        n_out.invalid = (t_val <= 0);
        // A non-positive t gives a zero radicand; the result is masked later.
        n_out.rad = n_out.invalid ? '0 : (RAD_W'(t_val) << FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_front = r_out;

endmodule
`default_nettype wire

### rtl/rmq_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage; the front-end
// data travels alongside.
// ----------------------------------------------------------------------------
module rmq_sqrt import rmq_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_front i_front,
    output t_front      o_front,
    output logic [ROOT_W-1:0] o_root
);

    t_front           r_pay [SQ_STAGES];
    logic [RAD_W-1:0] r_x   [SQ_STAGES];
    logic [RAD_W-1:0] r_res [SQ_STAGES];
    t_front           n_pay [SQ_STAGES];
    logic [RAD_W-1:0] n_x   [SQ_STAGES];
    logic [RAD_W-1:0] n_res [SQ_STAGES];

    always_comb begin
        logic [RAD_W-1:0] px, pres, bitv, trial;
        for (int k = 0; k < SQ_STAGES; k++) begin
            if (k == 0) begin
                n_pay[k] = i_front;
                px       = i_front.rad;
                pres     = '0;
            end else begin
                n_pay[k] = r_pay[k-1];
                px       = r_x[k-1];
                pres     = r_res[k-1];
            end
            bitv  = RAD_W'(1) << (RAD_W - 2 - 2 * k);
            trial = pres + bitv;
            if (px >= trial) begin
                n_x[k]   = px - trial;
                n_res[k] = (pres >> 1) + bitv;
            end else begin
                n_x[k]   = px;
                n_res[k] = pres >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQ_STAGES; k++) begin
            r_pay[k] <= n_pay[k];
            r_x[k]   <= n_x[k];
            r_res[k] <= n_res[k];
            if (!i_rst_n) begin
                r_pay[k].valid <= 1'b0;
            end
        end
    end

    assign o_front = r_pay[SQ_STAGES-1];
    assign o_root  = r_res[SQ_STAGES-1][ROOT_W-1:0];

endmodule
`default_nettype wire

### rtl/rmq_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div import rmq_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic             i_neg,
    output logic [NUM_W-1:0]      o_quot,
    output logic                  o_neg
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_q   [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic             r_neg [NUM_W];
    logic [DEN_W-1:0] n_rem [NUM_W];
    logic [NUM_W-1:0] n_num [NUM_W];
    logic [NUM_W-1:0] n_q   [NUM_W];
    logic [DEN_W-1:0] n_den [NUM_W];
    logic             n_neg [NUM_W];

    always_comb begin
        logic [DEN_W-1:0] prem;
        logic [NUM_W-1:0] pnum, pq;
        logic [DEN_W:0]   trial;
        for (int k = 0; k < NUM_W; k++) begin
            if (k == 0) begin
                prem     = '0;
                pnum     = i_num;
                pq       = '0;
                n_den[k] = i_den;
                n_neg[k] = i_neg;
            end else begin
                prem     = r_rem[k-1];
                pnum     = r_num[k-1];
                pq       = r_q[k-1];
                n_den[k] = r_den[k-1];
                n_neg[k] = r_neg[k-1];
            end
            trial    = {prem, pnum[NUM_W-1]};
            n_num[k] = pnum << 1;
            if (trial >= {1'b0, n_den[k]}) begin
                n_rem[k] = DEN_W'(trial - {1'b0, n_den[k]});
                n_q[k]   = {pq[NUM_W-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[DEN_W-1:0];
                n_q[k]   = {pq[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_W; k++) begin
            r_rem[k] <= n_rem[k];
            r_num[k] <= n_num[k];
            r_q[k]   <= n_q[k];
            r_den[k] <= n_den[k];
            r_neg[k] <= n_neg[k];
        end
    end

    assign o_quot = r_q[NUM_W-1];
    assign o_neg  = r_neg[NUM_W-1];

endmodule
`default_nettype wire
